FILE: src/pid_relay_temperature_control_macros.svh
// Assertion macros for the verification module of the relay PID block
`ifndef PID_RELAY_TEMPERATURE_CONTROL_MACROS_SVH
`define PID_RELAY_TEMPERATURE_CONTROL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PRTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("prtc assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define PRTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("prtc assertion failed");

`endif

FILE: src/prtc_pkg.sv
// Shared types and constants for the relay PID temperature controller
`default_nettype none

package prtc_pkg;

    // Register bus geometry
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    // Register indexes, byte address is 4 * index
    typedef enum logic [2:0] {
        REG_SETPOINT   = 3'd0,
        REG_GAIN_P     = 3'd1,
        REG_GAIN_I     = 3'd2,
        REG_GAIN_D     = 3'd3,
        REG_INT_LIMIT  = 3'd4,
        REG_HOLD_BAND  = 3'd5
    } t_reg_idx;

    // Reset values
    localparam logic [15:0] SETPOINT_RST  = 16'h0000;
    localparam logic [15:0] GAIN_RST      = 16'h0100;  // 1.0 in Q8.8
    localparam logic [15:0] INT_LIMIT_RST = 16'h0000;
    localparam logic [14:0] HOLD_BAND_RST = 15'h0000;

    // Integral and drive saturation bounds
    localparam logic [23:0] SUM_MAX   = 24'h7F_FFFF;
    localparam logic [23:0] SUM_MIN   = 24'h80_0000;
    localparam logic [31:0] DRIVE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] DRIVE_MIN = 32'h8000_0000;

    // Relay mode codes
    typedef enum logic [1:0] {
        MODE_HOLD = 2'd0,
        MODE_HEAT = 2'd1,
        MODE_COOL = 2'd2
    } t_relay_mode;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [15:0] setpoint;
        logic [15:0] gain_p;
        logic [15:0] gain_i;
        logic [15:0] gain_d;
        logic [15:0] int_limit;
        logic [14:0] hold_band;
    } t_cfg;

    // Error stage result: all two's complement
    typedef struct packed {
        logic [16:0] err;
        logic [23:0] error_sum;
        logic [16:0] diff;
    } t_integ;

    // Product stage result: all two's complement
    typedef struct packed {
        logic [32:0] prod_p;
        logic [39:0] prod_i;
        logic [32:0] prod_d;
    } t_prod;

endpackage

`default_nettype wire

FILE: src/prtc_regs.sv
// Configuration register file behind the APB-style port
`default_nettype none

module prtc_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [prtc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [prtc_pkg::DATA_W-1:0]  pwdata,
    output logic      [prtc_pkg::DATA_W-1:0]  prdata,
    output logic                              pready,
    output prtc_pkg::t_cfg                    o_cfg
);

    logic [15:0] r_setpoint;
    logic [15:0] r_gain_p;
    logic [15:0] r_gain_i;
    logic [15:0] r_gain_d;
    logic [15:0] r_int_limit;
    logic [14:0] r_hold_band;

    logic               w_wr;
    prtc_pkg::t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = prtc_pkg::t_reg_idx'(paddr[4:2]);

    // Register writes, indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint  <= prtc_pkg::SETPOINT_RST;
            r_gain_p    <= prtc_pkg::GAIN_RST;
            r_gain_i    <= prtc_pkg::GAIN_RST;
            r_gain_d    <= prtc_pkg::GAIN_RST;
            r_int_limit <= prtc_pkg::INT_LIMIT_RST;
            r_hold_band <= prtc_pkg::HOLD_BAND_RST;
        end else if (w_wr) begin
            case (w_idx)
                prtc_pkg::REG_SETPOINT:  r_setpoint  <= pwdata[15:0];
                prtc_pkg::REG_GAIN_P:    r_gain_p    <= pwdata[15:0];
                prtc_pkg::REG_GAIN_I:    r_gain_i    <= pwdata[15:0];
                prtc_pkg::REG_GAIN_D:    r_gain_d    <= pwdata[15:0];
                prtc_pkg::REG_INT_LIMIT: r_int_limit <= pwdata[15:0];
                prtc_pkg::REG_HOLD_BAND: r_hold_band <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (w_idx)
            prtc_pkg::REG_SETPOINT:  prdata = {16'h0000, r_setpoint};
            prtc_pkg::REG_GAIN_P:    prdata = {16'h0000, r_gain_p};
            prtc_pkg::REG_GAIN_I:    prdata = {16'h0000, r_gain_i};
            prtc_pkg::REG_GAIN_D:    prdata = {16'h0000, r_gain_d};
            prtc_pkg::REG_INT_LIMIT: prdata = {16'h0000, r_int_limit};
            prtc_pkg::REG_HOLD_BAND: prdata = {17'h00000, r_hold_band};
            default:                 prdata = '0;
        endcase
    end

    assign o_cfg = '{setpoint:  r_setpoint,
                     gain_p:    r_gain_p,
                     gain_i:    r_gain_i,
                     gain_d:    r_gain_d,
                     int_limit: r_int_limit,
                     hold_band: r_hold_band};

endmodule

`default_nettype wire

FILE: src/prtc_integ.sv
// Input register, error and saturating integral with reset-on-threshold
`default_nettype none

module prtc_integ (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [15:0]        i_sample,
    input  wire prtc_pkg::t_cfg     i_cfg,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output prtc_pkg::t_integ        o_data
);

    logic             r_in_valid;
    logic [15:0]      r_in_sample;
    logic             r_s1_valid;
    prtc_pkg::t_integ r_s1;
    logic [23:0]      r_error_sum;
    logic [15:0]      r_prev_sample;

    logic        w_s1_ready;
    logic        w_in_ready;
    logic        w_adv;
    logic [16:0] n_err;
    logic [16:0] n_diff;
    logic [24:0] w_sum_ext;
    logic [23:0] w_sum_sat;
    logic        w_keep;
    logic [23:0] n_error_sum;

    // Two-deep flow control: each stage loads when it is empty or drains
    assign w_s1_ready = ~r_s1_valid | i_ready;
    assign w_in_ready = ~r_in_valid | w_s1_ready;
    assign w_adv      = r_in_valid & w_s1_ready;
    assign o_ready    = w_in_ready;

    // Error and derivative difference, both exact at 17 bits
    assign n_err  = {i_cfg.setpoint[15], i_cfg.setpoint}
                  - {r_in_sample[15], r_in_sample};
    assign n_diff = {r_prev_sample[15], r_prev_sample}
                  - {r_in_sample[15], r_in_sample};

    // Integral: accumulate below the limit, clear at or above it
    assign w_keep    = $signed(n_err) < $signed({i_cfg.int_limit[15], i_cfg.int_limit});
    assign w_sum_ext = {r_error_sum[23], r_error_sum} + {{8{n_err[16]}}, n_err};
    assign w_sum_sat = (w_sum_ext[24] != w_sum_ext[23])
                     ? (w_sum_ext[24] ? prtc_pkg::SUM_MIN : prtc_pkg::SUM_MAX)
                     : w_sum_ext[23:0];
    assign n_error_sum = w_keep ? w_sum_sat : 24'h00_0000;

    // Control and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_s1_valid    <= 1'b0;
            r_error_sum   <= '0;
            r_prev_sample <= '0;
        end else begin
            if (w_in_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_s1_ready) begin
                r_s1_valid <= r_in_valid;
            end
            if (w_adv) begin
                r_error_sum   <= n_error_sum;
                r_prev_sample <= r_in_sample;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_in_ready) begin
            r_in_sample <= i_sample;
        end
        if (w_adv) begin
            r_s1 <= '{err: n_err, error_sum: n_error_sum, diff: n_diff};
        end
    end

    assign o_valid = r_s1_valid;
    assign o_data  = r_s1;

endmodule

`default_nettype wire

FILE: src/prtc_mult.sv
// Product stage: the three gain multiplies, registered
`default_nettype none

module prtc_mult (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire prtc_pkg::t_integ   i_data,
    input  wire prtc_pkg::t_cfg     i_cfg,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output prtc_pkg::t_prod         o_data
);

    logic            r_valid;
    prtc_pkg::t_prod r_prod;

    logic               w_ready;
    logic signed [32:0] n_prod_p;
    logic signed [39:0] n_prod_i;
    logic signed [32:0] n_prod_d;

    assign w_ready = ~r_valid | i_ready;
    assign o_ready = w_ready;

    // Signed products at full width
    assign n_prod_p = $signed(i_cfg.gain_p) * $signed(i_data.err);
    assign n_prod_i = $signed(i_cfg.gain_i) * $signed(i_data.error_sum);
    assign n_prod_d = $signed(i_cfg.gain_d) * $signed(i_data.diff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready & i_valid) begin
            r_prod <= '{prod_p: n_prod_p, prod_i: n_prod_i, prod_d: n_prod_d};
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_prod;

endmodule

`default_nettype wire

FILE: src/prtc_drive.sv
// Result stage: sum, floor scaling to Q24.8, saturation and relay decision
`default_nettype none

module prtc_drive (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire prtc_pkg::t_prod    i_data,
    input  wire prtc_pkg::t_cfg     i_cfg,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output prtc_pkg::t_relay_mode   o_mode,
    output logic [31:0]             o_drive
);

    logic                  r_valid;
    prtc_pkg::t_relay_mode r_mode;
    logic [31:0]           r_drive;

    logic                  w_ready;
    logic signed [40:0]    w_acc;
    logic [32:0]           w_scaled;
    logic [31:0]           n_drive;
    logic [32:0]           w_margin;
    prtc_pkg::t_relay_mode n_mode;

    assign w_ready = ~r_valid | i_ready;
    assign o_ready = w_ready;

    // Q16.16 sum; dropping the low byte of two's complement is a floor
    assign w_acc    = $signed(i_data.prod_p) + $signed(i_data.prod_i)
                    + $signed(i_data.prod_d);
    assign w_scaled = w_acc[40:8];
    assign n_drive  = (w_scaled[32] != w_scaled[31])
                    ? (w_scaled[32] ? prtc_pkg::DRIVE_MIN : prtc_pkg::DRIVE_MAX)
                    : w_scaled[31:0];

    // Cool when drive + hold_band < 0, heat when drive >= 0
    assign w_margin = {n_drive[31], n_drive} + {18'h00000, i_cfg.hold_band};

    always_comb begin
        if (w_margin[32]) begin
            n_mode = prtc_pkg::MODE_COOL;
        end else if (!n_drive[31]) begin
            n_mode = prtc_pkg::MODE_HEAT;
        end else begin
            n_mode = prtc_pkg::MODE_HOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready & i_valid) begin
            r_mode  <= n_mode;
            r_drive <= n_drive;
        end
    end

    assign o_valid = r_valid;
    assign o_mode  = r_mode;
    assign o_drive = r_drive;

endmodule

`default_nettype wire

FILE: src/pid_relay_temperature_control.sv
// Top level of the relay PID temperature controller
//
//   channel   dir  handshake                  payload
//   sample    in   i_in_valid / o_in_stall    i_sample[15:0] signed Q8.8
//   result    out  o_out_valid / i_out_stall  o_relay_mode[1:0], o_drive_value[31:0]
//   config    in   psel/penable/pwrite/pready paddr[4:0], pwdata, prdata
//
// One request per cycle sustained while i_out_stall is low; a sample passes the
// input register, error/integral, multiplies and sum/saturate registers in turn.
// Reset (synchronous, active low) empties the pipe, clears the integral and
// the last sample and loads the register defaults.
// A stall on the result side fills the four stages before o_in_stall rises.
`default_nettype none

module pid_relay_temperature_control (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [15:0]                  i_sample,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [1:0]                        o_relay_mode,
    output logic [31:0]                       o_drive_value,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [prtc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [prtc_pkg::DATA_W-1:0]  pwdata,
    output logic      [prtc_pkg::DATA_W-1:0]  prdata,
    output logic                              pready
);

    prtc_pkg::t_cfg        w_cfg;
    logic                  w_in_ready;
    logic                  w_s1_valid;
    logic                  w_s1_ready;
    prtc_pkg::t_integ      w_s1_data;
    logic                  w_s2_valid;
    logic                  w_s2_ready;
    prtc_pkg::t_prod       w_s2_data;
    prtc_pkg::t_relay_mode w_mode;

    prtc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    prtc_integ u_integ (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (w_in_ready),
        .i_sample (i_sample),
        .i_cfg    (w_cfg),
        .o_valid  (w_s1_valid),
        .i_ready  (w_s1_ready),
        .o_data   (w_s1_data)
    );

    prtc_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .o_ready (w_s1_ready),
        .i_data  (w_s1_data),
        .i_cfg   (w_cfg),
        .o_valid (w_s2_valid),
        .i_ready (w_s2_ready),
        .o_data  (w_s2_data)
    );

    prtc_drive u_drive (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s2_valid),
        .o_ready (w_s2_ready),
        .i_data  (w_s2_data),
        .i_cfg   (w_cfg),
        .o_valid (o_out_valid),
        .i_ready (~i_out_stall),
        .o_mode  (w_mode),
        .o_drive (o_drive_value)
    );

    assign o_in_stall   = ~w_in_ready;
    assign o_relay_mode = w_mode;

endmodule

`default_nettype wire

FILE: src/prtc_monitor.sv
// Port-level assertions for the relay PID controller, bound to the top level
`default_nettype none

`include "pid_relay_temperature_control_macros.svh"

module prtc_monitor (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_in_stall,
    input wire logic         o_out_valid,
    input wire logic         i_out_stall,
    input wire logic [1:0]   o_relay_mode,
    input wire logic [31:0]  o_drive_value
);

    // A stalled result stays offered
    `PRTC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n,
                     o_out_valid && i_out_stall, o_out_valid)

    // Non-negative drive always turns the heater on
    `PRTC_ASSERT_IMP(a_heat_pos, i_clk, i_rst_n,
                     o_out_valid && !o_drive_value[31],
                     o_relay_mode == prtc_pkg::MODE_HEAT)

    // Negative drive never heats
    `PRTC_ASSERT_IMP(a_noheat_neg, i_clk, i_rst_n,
                     o_out_valid && o_drive_value[31],
                     o_relay_mode != prtc_pkg::MODE_HEAT)

    // With no result waiting the pipe always has room
    `PRTC_ASSERT_IMP(a_room, i_clk, i_rst_n, !o_out_valid, !o_in_stall)

endmodule

bind pid_relay_temperature_control prtc_monitor u_prtc_monitor (.*);

`default_nettype wire
